/* design/ole_pkg.sv */
package ole_pkg;

  localparam int OpW         = 3;
  localparam int PosW        = 7;
  localparam int ValW        = 32;
  localparam int StatusW     = 2;
  localparam int CountW      = 7;
  localparam int DefCapacity = 64;

  typedef enum logic [OpW-1:0] {
    OP_INSERT     = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_DELETE     = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // What the accepted request turned into after the range and full checks.
  typedef enum logic [2:0] {
    K_NONE,
    K_INSERT,
    K_DELETE,
    K_SEARCH,
    K_CLEAR
  } kind_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_APPLY,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    wr_val;
    cnt_op_t cnt_op;
    logic    res_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  sweep;
    logic  at_last;
    logic  res_free;
  } dp_status_t;

endpackage

/* design/ole_if.sv */
interface ole_req_if;
  logic                             valid;
  logic                             ready;
  logic [ole_pkg::OpW-1:0]          opcode;
  logic [ole_pkg::PosW-1:0]         position;
  logic signed [ole_pkg::ValW-1:0]  value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface ole_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ole_pkg::StatusW-1:0]   status;
  logic                          found;
  logic [ole_pkg::CountW-1:0]    count;

  modport source (output valid, output status, output found, output count, input ready);
  modport sink   (input valid, input status, input found, input count, output ready);
endinterface

/* design/ole_ctrl.sv */
module ole_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ole_pkg::dp_status_t st,
  output ole_pkg::dp_cmd_t    cmd
);

  ole_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ole_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd.load     = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.wr_val   = 1'b0;
    cmd.cnt_op   = ole_pkg::CNT_HOLD;
    cmd.res_load = 1'b0;
    unique case (state)
      ole_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ole_pkg::S_APPLY;
        end
      end
      ole_pkg::S_SWEEP: begin
        cmd.rd_en = 1'b1;
        if (st.at_last) begin
          state_next = ole_pkg::S_DRAIN;
        end
      end
      ole_pkg::S_DRAIN: begin
        // last moved entry or last compare lands here
        state_next = ole_pkg::S_APPLY;
      end
      ole_pkg::S_APPLY: begin
        unique case (st.kind)
          ole_pkg::K_INSERT: begin
            cmd.wr_val = 1'b1;
            cmd.cnt_op = ole_pkg::CNT_INC;
          end
          ole_pkg::K_DELETE: cmd.cnt_op = ole_pkg::CNT_DEC;
          ole_pkg::K_CLEAR:  cmd.cnt_op = ole_pkg::CNT_CLR;
          default:           cmd.cnt_op = ole_pkg::CNT_HOLD;
        endcase
        state_next = ole_pkg::S_FINISH;
      end
      ole_pkg::S_FINISH: begin
        if (st.res_free) begin
          cmd.res_load = 1'b1;
          state_next   = ole_pkg::S_IDLE;
        end
      end
      default: state_next = ole_pkg::S_IDLE;
    endcase
    // a request that needs entries moved or scanned sweeps first
    if (state == ole_pkg::S_IDLE && req_valid && st.sweep) begin
      state_next = ole_pkg::S_SWEEP;
    end
  end

endmodule

/* design/ole_dp.sv */
module ole_dp #(
  parameter int CAPACITY = ole_pkg::DefCapacity
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ole_pkg::OpW-1:0]           opcode,
  input  logic [ole_pkg::PosW-1:0]          position,
  input  logic signed [ole_pkg::ValW-1:0]   value,
  input  ole_pkg::dp_cmd_t                  cmd,
  output ole_pkg::dp_status_t               st,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [ole_pkg::StatusW-1:0]       rsp_status,
  output logic                              rsp_found,
  output logic [ole_pkg::CountW-1:0]        rsp_count
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMPW = (CW > ole_pkg::PosW) ? CW : ole_pkg::PosW;

  logic [ole_pkg::ValW-1:0] mem [CAPACITY];

  logic [CW-1:0]            count;
  ole_pkg::kind_t           kind;
  ole_pkg::status_t         st_code;
  logic [AW-1:0]            idx;
  logic [AW-1:0]            last;
  logic [AW-1:0]            ins_pos;
  logic [ole_pkg::ValW-1:0] val;
  logic [ole_pkg::ValW-1:0] rdata;
  logic                     pend_v;
  logic [AW-1:0]            pend_addr;
  logic                     cmp_v;
  logic                     found;

  // request decode, evaluated against the count at the transfer
  ole_pkg::kind_t   kind_next;
  ole_pkg::status_t st_next;
  logic             sweep_next;
  logic [AW-1:0]    idx_next;
  logic [AW-1:0]    last_next;
  logic [AW-1:0]    ins_next;
  logic [CMPW-1:0]  cnt_w;
  logic [CMPW-1:0]  pos_w;
  logic             full;
  logic [AW-1:0]    cnt_m1;

  always_comb begin
    cnt_w      = CMPW'(count);
    pos_w      = CMPW'(position);
    full       = (count == CW'(CAPACITY));
    cnt_m1     = AW'(count - 1'b1);
    kind_next  = ole_pkg::K_NONE;
    st_next    = ole_pkg::ST_OK;
    sweep_next = 1'b0;
    idx_next   = cnt_m1;
    last_next  = AW'(position);
    ins_next   = AW'(position);
    unique case (opcode)
      ole_pkg::OP_INSERT: begin
        if (pos_w > cnt_w) begin
          st_next = ole_pkg::ST_BAD_INDEX;
        end else if (full) begin
          st_next = ole_pkg::ST_FULL;
        end else begin
          kind_next  = ole_pkg::K_INSERT;
          sweep_next = (pos_w < cnt_w);
        end
      end
      ole_pkg::OP_PUSH_FRONT: begin
        last_next = '0;
        ins_next  = '0;
        if (full) begin
          st_next = ole_pkg::ST_FULL;
        end else begin
          kind_next  = ole_pkg::K_INSERT;
          sweep_next = (count != '0);
        end
      end
      ole_pkg::OP_PUSH_BACK: begin
        ins_next = AW'(count);
        if (full) begin
          st_next = ole_pkg::ST_FULL;
        end else begin
          kind_next = ole_pkg::K_INSERT;
        end
      end
      ole_pkg::OP_DELETE: begin
        idx_next  = AW'(pos_w + CMPW'(1));
        last_next = cnt_m1;
        if (pos_w >= cnt_w) begin
          st_next = ole_pkg::ST_BAD_INDEX;
        end else begin
          kind_next  = ole_pkg::K_DELETE;
          sweep_next = ((pos_w + CMPW'(1)) < cnt_w);
        end
      end
      ole_pkg::OP_SEARCH: begin
        kind_next  = ole_pkg::K_SEARCH;
        idx_next   = '0;
        last_next  = cnt_m1;
        sweep_next = (count != '0);
      end
      ole_pkg::OP_CLEAR: kind_next = ole_pkg::K_CLEAR;
      default:           kind_next = ole_pkg::K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind    <= kind_next;
      st_code <= st_next;
      last    <= last_next;
      ins_pos <= ins_next;
      val     <= value;
    end
  end

  // sweep address: insert walks down, delete and search walk up
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= idx_next;
    end else if (cmd.rd_en) begin
      if (kind == ole_pkg::K_INSERT) begin
        idx <= idx - 1'b1;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      cmp_v  <= 1'b0;
    end else begin
      pend_v <= cmd.rd_en && (kind == ole_pkg::K_INSERT || kind == ole_pkg::K_DELETE);
      cmp_v  <= cmd.rd_en && (kind == ole_pkg::K_SEARCH);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      pend_addr <= (kind == ole_pkg::K_INSERT) ? idx + 1'b1 : idx - 1'b1;
    end
  end

  // single read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[idx];
    end
  end

  // single write port: moved entry during the sweep, new value at apply
  always_ff @(posedge clk) begin
    if (cmd.wr_val) begin
      mem[ins_pos] <= val;
    end else if (pend_v) begin
      mem[pend_addr] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found <= 1'b0;
    end else if (cmp_v && rdata == val) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.cnt_op)
        ole_pkg::CNT_INC:  count <= count + 1'b1;
        ole_pkg::CNT_DEC:  count <= count - 1'b1;
        ole_pkg::CNT_CLR:  count <= '0;
        ole_pkg::CNT_HOLD: count <= count;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_status <= st_code;
      rsp_found  <= found;
      rsp_count  <= ole_pkg::CountW'(count);
    end
  end

  always_comb begin
    st.kind     = cmd.load ? kind_next : kind;
    st.sweep    = sweep_next;
    st.at_last  = (idx == last);
    st.res_free = !rsp_valid || rsp_ready;
  end

endmodule

/* design/ordered_list_engine.sv */
// Channel  Dir  Payload                          Transfer
// req      in   opcode, position, value          req.valid & req.ready
// rsp      out  status, found, count             rsp.valid & rsp.ready
//
// One request at a time; req.ready is high only while the engine is idle.
// A request passes idle, apply and finish; one that moves entries (insert,
// delete) or compares them (search) first sweeps and drains, through the
// single read and single write port of the entry memory.
// rst is synchronous and clears the count, the controller and rsp.valid.
// A held result stalls the engine in finish; no request is taken meanwhile.
module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::DefCapacity
) (
  input  logic  clk,
  input  logic  rst,
  ole_req_if.sink   req,
  ole_rsp_if.source rsp
);

  ole_pkg::dp_cmd_t    cmd;
  ole_pkg::dp_status_t st;
  logic                ready;

  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .st        (st),
    .cmd       (cmd)
  );

  ole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .opcode     (req.opcode),
    .position   (req.position),
    .value      (req.value),
    .cmd        (cmd),
    .st         (st),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_found  (rsp.found),
    .rsp_count  (rsp.count)
  );

  assign req.ready = ready;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in flight");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!rsp.valid || rsp.ready))
    else $error("result overwritten before transfer");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> rsp.valid)
    else $error("loaded result not presented");

  a_grow_on_insert: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_op == ole_pkg::CNT_INC) |-> (cmd.wr_val && st.kind == ole_pkg::K_INSERT))
    else $error("count grew without an insert");

endmodule

/* tb/ordered_list_engine_checker.sv */
module ordered_list_engine_checker
  import ole_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  logic clk,
  input  logic rst,
  ole_req_if   req,
  ole_rsp_if   rsp,
  output int   mismatches,
  output int   list_len,
  output int   pending
);

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [CountW-1:0]   count;
  } outcome_t;

  logic signed [ValW-1:0] shelf [$];
  outcome_t               awaited_outcomes [$];

  initial mismatches = 0;

  // Apply one request to the local copy of the list and return its outcome.
  function automatic outcome_t apply_request(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                                             logic signed [ValW-1:0] val);
    outcome_t o;
    int       n;
    o.status = ST_OK;
    o.found  = 1'b0;
    n        = shelf.size();
    case (op)
      OP_INSERT: begin
        if (pos > n) begin
          o.status = ST_BAD_INDEX;
        end else if (n >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          shelf.insert(pos, val);
        end
      end
      OP_PUSH_FRONT: begin
        if (n >= CAPACITY) o.status = ST_FULL;
        else shelf.push_front(val);
      end
      OP_PUSH_BACK: begin
        if (n >= CAPACITY) o.status = ST_FULL;
        else shelf.push_back(val);
      end
      OP_DELETE: begin
        if (pos >= n) o.status = ST_BAD_INDEX;
        else shelf.delete(pos);
      end
      OP_SEARCH: begin
        foreach (shelf[i]) begin
          if (shelf[i] == val) o.found = 1'b1;
        end
      end
      OP_CLEAR: shelf.delete();
      default: ;
    endcase
    o.count = CountW'(shelf.size());
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      shelf.delete();
      awaited_outcomes.delete();
      list_len <= 0;
      pending  <= 0;
    end else begin
      // Check the result first: a result can never belong to a request taken at the same edge.
      if (rsp.valid && rsp.ready) begin
        got.status = status_t'(rsp.status);
        got.found  = rsp.found;
        got.count  = rsp.count;
        if (awaited_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d found %0d count %0d",
                     got.status, got.found, got.count);
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: status %0d/%0d found %0d/%0d count %0d/%0d (expected/actual)",
                       want.status, got.status, want.found, got.found, want.count, got.count);
          end
        end
      end
      if (req.valid && req.ready)
        awaited_outcomes.push_back(apply_request(req.opcode, req.position, req.value));
      list_len <= shelf.size();
      pending  <= awaited_outcomes.size();
    end
  end

endmodule

/* tb/ordered_list_engine_tb.sv */
module ordered_list_engine_tb;
  import ole_pkg::*;

  localparam int Capacity       = DefCapacity;
  localparam int WatchdogLimit  = 4000;
  localparam int PressureCycles = 300;
  localparam int RandomItems    = 475;
  localparam int SettleCycles   = 100;
  localparam int MaxPos         = (1 << PosW) - 1;

  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;

  localparam logic signed [ValW-1:0] ValMin  = {1'b1, {(ValW-1){1'b0}}};
  localparam logic signed [ValW-1:0] ValMax  = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValOnes = {ValW{1'b1}};

  typedef enum {AT_ABS, AT_END, AT_SPAN} aim_t;
  typedef enum {MIX_FILL, MIX_GROW, MIX_SHRINK, MIX_NOISE} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ole_req_if req ();
  ole_rsp_if rsp ();

  int mismatches;
  int list_len;
  int pending;
  int idle_cycles = 0;
  int sent = 0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  bit hold_off = 1'b0;

  ordered_list_engine #(.CAPACITY(Capacity)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  ordered_list_engine_checker #(.CAPACITY(Capacity)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .list_len   (list_len),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return ValMin;
      1: return ValMax;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 15) - 8;
    endcase
  endfunction

  // Offer one request; the position is resolved against the live count after the gap.
  task automatic send_item(input logic [OpW-1:0] op, input aim_t aim, input int offset,
                           input logic signed [ValW-1:0] val);
    int gap;
    int p;
    gap = src_gaps ? $urandom_range(0, 13) : 0;
    @(posedge clk);
    repeat (gap) @(posedge clk);
    case (aim)
      AT_ABS:  p = offset;
      AT_END:  p = list_len + offset;
      default: p = $urandom_range(0, list_len);
    endcase
    if (p < 0) p = 0;
    if (p > MaxPos) p = MaxPos;
    req.opcode   <= op;
    req.position <= PosW'(p);
    req.value    <= val;
    req.valid    <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic random_item(input mix_t mix);
    logic [OpW-1:0] op;
    aim_t           aim;
    int             off;
    int             r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   op = (r < 40) ? OP_INSERT : (r < 70) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      MIX_GROW:   op = (r < 25) ? OP_INSERT : (r < 40) ? OP_PUSH_FRONT :
                       (r < 55) ? OP_PUSH_BACK : (r < 70) ? OP_DELETE :
                       (r < 97) ? OP_SEARCH : OP_CLEAR;
      MIX_SHRINK: op = (r < 55) ? OP_DELETE : (r < 65) ? OP_INSERT :
                       (r < 88) ? OP_SEARCH : (r < 96) ? OP_PUSH_BACK : OP_CLEAR;
      default:    op = OpW'($urandom_range(0, 7));
    endcase
    off = 0;
    if (mix == MIX_NOISE) begin
      aim = AT_ABS;
      off = $urandom_range(0, MaxPos);
    end else if (mix == MIX_FILL) begin
      aim = AT_SPAN;
    end else begin
      case ($urandom_range(0, 9))
        0: aim = AT_ABS;
        1: begin aim = AT_END; off = -1; end
        2: aim = AT_END;
        3: begin aim = AT_END; off = 1; end
        4: begin aim = AT_ABS; off = $urandom_range(0, MaxPos); end
        default: aim = AT_SPAN;
      endcase
    end
    send_item(op, aim, off, pick_value());
    sent++;
  endtask

  // Fill to capacity, then poke at the full list.
  task automatic fill_up();
    while (list_len < Capacity) random_item(MIX_FILL);
    send_item(OP_PUSH_FRONT, AT_ABS, 0, pick_value());
    send_item(OP_PUSH_BACK, AT_ABS, 0, pick_value());
    send_item(OP_INSERT, AT_END, 0, pick_value());
    send_item(OP_INSERT, AT_END, 1, pick_value());
    send_item(OP_SEARCH, AT_ABS, 0, pick_value());
    send_item(OP_DELETE, AT_END, 0, pick_value());
    send_item(OP_DELETE, AT_END, -1, pick_value());
    sent += 7;
  endtask

  initial begin : sink_side
    int hold;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        hold     = PressureCycles;
        hold_off = 1'b0;
      end else begin
        hold = sink_gaps ? $urandom_range(0, 13) : 0;
      end
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int  episode_len;
    bit  pressure_done;
    mix_t mix;
    pressure_done = 1'b0;
    req.valid    <= 1'b0;
    req.opcode   <= OP_SEARCH;
    req.position <= '0;
    req.value    <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed: empty list, edges of the index range, extremes of the value.
    send_item(OP_DELETE, AT_ABS, 0, 0);
    send_item(OP_SEARCH, AT_ABS, 0, 0);
    send_item(OP_INSERT, AT_ABS, 1, 1);
    send_item(OP_PUSH_BACK, AT_ABS, 0, ValMax);
    send_item(OP_PUSH_FRONT, AT_ABS, 0, ValMin);
    send_item(OP_INSERT, AT_ABS, 1, 0);
    send_item(OP_INSERT, AT_END, 0, ValOnes);
    send_item(OP_INSERT, AT_END, 1, 5);
    send_item(OP_INSERT, AT_ABS, MaxPos, 6);
    send_item(OP_SEARCH, AT_ABS, 0, ValMin);
    send_item(OP_SEARCH, AT_ABS, 0, ValOnes);
    send_item(OP_SEARCH, AT_ABS, 0, 32'sd12345);
    send_item(OP_SPARE_LO, AT_ABS, MaxPos, ValOnes);
    send_item(OP_SPARE_HI, AT_ABS, 0, 0);
    send_item(OP_DELETE, AT_END, -1, 0);
    send_item(OP_DELETE, AT_END, 0, 0);
    send_item(OP_DELETE, AT_ABS, 0, 0);
    send_item(OP_DELETE, AT_ABS, MaxPos, 0);
    send_item(OP_SEARCH, AT_ABS, 0, ValMax);
    send_item(OP_CLEAR, AT_ABS, 0, 0);
    send_item(OP_SEARCH, AT_ABS, 0, 0);
    send_item(OP_INSERT, AT_ABS, 0, 32'sh5555_5555);
    send_item(OP_INSERT, AT_ABS, 1, 32'shAAAA_AAAA);
    send_item(OP_SEARCH, AT_ABS, 0, 32'shAAAA_AAAA);

    fill_up();
    while (sent < RandomItems) begin
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      if (!pressure_done && sent >= 150) begin
        // Stall the result side long enough for requests to back up.
        hold_off      = 1'b1;
        src_gaps      = 1'b0;
        pressure_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: mix = MIX_FILL;
        1, 2: mix = MIX_NOISE;
        3, 4, 5: mix = MIX_SHRINK;
        default: mix = MIX_GROW;
      endcase
      if (mix == MIX_FILL) begin
        fill_up();
      end else begin
        episode_len = $urandom_range(20, 40);
        repeat (episode_len) random_item(mix);
      end
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
